// ===== rtl/wmmd_pkg.sv =====
// Shared constants and types for the waveform min/max decimator.
`default_nettype none

package wmmd_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_HEIGHT   = 8'd1;

    // Register and field widths fixed by the block's definition
    localparam int WLEN_W   = 13;
    localparam int HEIGHT_W = 12;
    localparam int ROW_W    = 12;

    // Register reset values
    localparam logic [WLEN_W-1:0]   WINDOW_LENGTH_RST = 13'd4;
    localparam logic [HEIGHT_W-1:0] VIEW_HEIGHT_RST   = 12'd256;

    // Shortest window the block runs
    localparam int MIN_WINDOW = 4;

    // Window record queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Point sequencer of the back end
    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_FIRST,
        EMIT_MID,
        EMIT_LAST
    } emit_state_t;

endpackage

`default_nettype wire

// ===== rtl/wmmd_if.sv =====
// Valid/ready channel interfaces for samples, points and configuration writes.
`default_nettype none

interface wmmd_sample_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_view;

    modport source (output valid, output sample, output end_of_view, input ready);
    modport sink   (input valid, input sample, input end_of_view, output ready);
endinterface

interface wmmd_point_if #(
    parameter int POSITION_BITS = 24
) ();
    import wmmd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [POSITION_BITS-1:0] x_position;
    logic [ROW_W-1:0]         y_row;
    logic                     starts_path;
    logic                     last_of_run;

    modport source (output valid, output x_position, output y_row, output starts_path,
                    output last_of_run, input ready);
    modport sink   (input valid, input x_position, input y_row, input starts_path,
                    input last_of_run, output ready);
endinterface

interface wmmd_cfg_if ();
    import wmmd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/wmmd_front.sv =====
// Front end: takes samples, tracks window extremes and queues completed windows.
`default_nettype none

module wmmd_front #(
    parameter int MAX_WINDOW    = 4096,
    parameter int SAMPLE_BITS   = 16,
    parameter int POSITION_BITS = 24,
    localparam int REC_W        = 2 * SAMPLE_BITS + 3 * POSITION_BITS + 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    wmmd_sample_if.sink                       samples,
    input  wire logic [wmmd_pkg::WLEN_W-1:0]  window_length,
    input  wire logic                         q_full,
    output logic                              q_push,
    output logic [REC_W-1:0]                  q_data
);
    import wmmd_pkg::*;

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int CMP_W = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;
    localparam logic signed [SAMPLE_BITS-1:0] MIN_INIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MAX_INIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] run_min_reg, run_min_next;
    logic signed [SAMPLE_BITS-1:0] run_max_reg, run_max_next;
    logic [IDX_W-1:0]              min_idx_reg, min_idx_next;
    logic [IDX_W-1:0]              max_idx_reg, max_idx_next;
    logic [LEN_W-1:0]              fill_reg, fill_next;
    logic [POSITION_BITS-1:0]      start_reg, start_next;
    logic                          path_open_reg, path_open_next;

    logic                          accept;
    logic [CMP_W-1:0]              wl_ext;
    logic [LEN_W-1:0]              len;
    logic                          take_min;
    logic                          take_max;
    logic signed [SAMPLE_BITS-1:0] new_min;
    logic signed [SAMPLE_BITS-1:0] new_max;
    logic [IDX_W-1:0]              new_min_idx;
    logic [IDX_W-1:0]              new_max_idx;
    logic [LEN_W-1:0]              fill_inc;
    logic                          complete;
    logic [POSITION_BITS-1:0]      x_mid;
    logic [POSITION_BITS-1:0]      x_end;

    assign samples.ready = !q_full;
    assign accept        = samples.valid && samples.ready;

    // Clamp the window length to the supported range
    always_comb
    begin
        wl_ext = CMP_W'(window_length);
        if (wl_ext < CMP_W'(MIN_WINDOW))
            len = LEN_W'(MIN_WINDOW);
        else if (wl_ext > CMP_W'(MAX_WINDOW))
            len = LEN_W'(MAX_WINDOW);
        else
            len = LEN_W'(wl_ext);
    end

    always_comb
    begin
        // Ties go to the later sample
        take_min    = samples.sample <= run_min_reg;
        take_max    = samples.sample >= run_max_reg;
        new_min     = take_min ? samples.sample : run_min_reg;
        new_max     = take_max ? samples.sample : run_max_reg;
        new_min_idx = take_min ? fill_reg[IDX_W-1:0] : min_idx_reg;
        new_max_idx = take_max ? fill_reg[IDX_W-1:0] : max_idx_reg;
        fill_inc    = fill_reg + LEN_W'(1);
        complete    = fill_inc >= len;
        x_mid       = start_reg + POSITION_BITS'(len >> 1);
        x_end       = start_reg + POSITION_BITS'(len);
    end

    assign q_push = accept && complete;
    assign q_data = {new_min, new_max, start_reg, x_mid, x_end,
                     new_min_idx < new_max_idx, !path_open_reg};

    always_comb
    begin
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        min_idx_next   = min_idx_reg;
        max_idx_next   = max_idx_reg;
        fill_next      = fill_reg;
        start_next     = start_reg;
        path_open_next = path_open_reg;
        if (accept)
        begin
            if (complete)
            begin
                run_min_next   = MIN_INIT;
                run_max_next   = MAX_INIT;
                min_idx_next   = '0;
                max_idx_next   = '0;
                fill_next      = '0;
                start_next     = x_end;
                path_open_next = 1'b1;
            end
            else
            begin
                run_min_next = new_min;
                run_max_next = new_max;
                min_idx_next = new_min_idx;
                max_idx_next = new_max_idx;
                fill_next    = fill_inc;
            end
            // Drop any partial window at the end marker
            if (samples.end_of_view)
            begin
                run_min_next   = MIN_INIT;
                run_max_next   = MAX_INIT;
                min_idx_next   = '0;
                max_idx_next   = '0;
                fill_next      = '0;
                start_next     = '0;
                path_open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg   <= MIN_INIT;
            run_max_reg   <= MAX_INIT;
            min_idx_reg   <= '0;
            max_idx_reg   <= '0;
            fill_reg      <= '0;
            start_reg     <= '0;
            path_open_reg <= 1'b0;
        end
        else
        begin
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            min_idx_reg   <= min_idx_next;
            max_idx_reg   <= max_idx_next;
            fill_reg      <= fill_next;
            start_reg     <= start_next;
            path_open_reg <= path_open_next;
        end
    end

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("window record pushed into a full queue");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && samples.end_of_view |=> fill_reg == '0 && start_reg == '0 && !path_open_reg)
        else $error("end marker did not clear the window");

    a_extremes_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != '0 |-> run_min_reg <= run_max_reg)
        else $error("running minimum above running maximum");
`endif

endmodule

`default_nettype wire

// ===== rtl/wmmd_queue.sv =====
// Short register queue of completed window records between front and back.
`default_nettype none

module wmmd_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data
);
    import wmmd_pkg::*;

    logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ===== rtl/wmmd_back.sv =====
// Back end: scales window extremes to rows and sequences three points per window.
`default_nettype none

module wmmd_back #(
    parameter int SAMPLE_BITS   = 16,
    parameter int POSITION_BITS = 24,
    localparam int REC_W        = 2 * SAMPLE_BITS + 3 * POSITION_BITS + 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [wmmd_pkg::HEIGHT_W-1:0] view_height,
    input  wire logic                          q_valid,
    input  wire logic [REC_W-1:0]              q_data,
    output logic                               q_pop,
    wmmd_point_if.source                       points
);
    import wmmd_pkg::*;

    localparam int SPAN_W = SAMPLE_BITS + 1;
    localparam int PROD_W = SPAN_W + HEIGHT_W;
    localparam logic [SPAN_W-1:0] HALF_SPAN = {2'b01, {(SAMPLE_BITS-1){1'b0}}};
    localparam int X2_LSB  = 2;
    localparam int X1_LSB  = X2_LSB + POSITION_BITS;
    localparam int X0_LSB  = X1_LSB + POSITION_BITS;
    localparam int MAX_LSB = X0_LSB + POSITION_BITS;
    localparam int MIN_LSB = MAX_LSB + SAMPLE_BITS;

    // Record fields at the queue head
    logic [SAMPLE_BITS-1:0]   q_min;
    logic [SAMPLE_BITS-1:0]   q_max;
    logic [SPAN_W-1:0]        span_min;
    logic [SPAN_W-1:0]        span_max;
    logic [PROD_W-1:0]        prod_min;
    logic [PROD_W-1:0]        prod_max;

    // Scaling stage
    logic                     s1_valid_reg, s1_valid_next;
    logic [ROW_W-1:0]         s1_row_min_reg;
    logic [ROW_W-1:0]         s1_row_max_reg;
    logic                     s1_min_first_reg;
    logic                     s1_starts_reg;
    logic [POSITION_BITS-1:0] s1_x0_reg;
    logic [POSITION_BITS-1:0] s1_x1_reg;
    logic [POSITION_BITS-1:0] s1_x2_reg;

    // Point sequencing stage
    emit_state_t              st_reg, st_next;
    logic [ROW_W-1:0]         s2_first_row_reg;
    logic [ROW_W-1:0]         s2_mid_row_reg;
    logic [ROW_W-1:0]         s2_last_row_reg;
    logic                     s2_starts_reg;
    logic [POSITION_BITS-1:0] s2_x0_reg;
    logic [POSITION_BITS-1:0] s2_x1_reg;
    logic [POSITION_BITS-1:0] s2_x2_reg;
    logic [ROW_W:0]           row_sum;
    logic                     s2_load;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic [POSITION_BITS-1:0] out_x_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic                     out_starts_reg;
    logic                     out_last_reg;
    logic                     load_out;
    logic                     out_load;
    logic [POSITION_BITS-1:0] pt_x;
    logic [ROW_W-1:0]         pt_row;
    logic                     pt_starts;
    logic                     pt_last;

    assign q_min = q_data[MIN_LSB +: SAMPLE_BITS];
    assign q_max = q_data[MAX_LSB +: SAMPLE_BITS];

    // Row = ((half scale - s) * height) >> SAMPLE_BITS
    always_comb
    begin
        span_min = HALF_SPAN - {q_min[SAMPLE_BITS-1], q_min};
        span_max = HALF_SPAN - {q_max[SAMPLE_BITS-1], q_max};
        prod_min = PROD_W'(span_min) * PROD_W'(view_height);
        prod_max = PROD_W'(span_max) * PROD_W'(view_height);
    end

    assign q_pop         = q_valid && (!s1_valid_reg || s2_load);
    assign s1_valid_next = q_pop ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_row_min_reg   <= prod_min[SAMPLE_BITS +: ROW_W];
            s1_row_max_reg   <= prod_max[SAMPLE_BITS +: ROW_W];
            s1_min_first_reg <= q_data[1];
            s1_starts_reg    <= q_data[0];
            s1_x0_reg        <= q_data[X0_LSB +: POSITION_BITS];
            s1_x1_reg        <= q_data[X1_LSB +: POSITION_BITS];
            s1_x2_reg        <= q_data[X2_LSB +: POSITION_BITS];
        end
    end

    assign row_sum  = {1'b0, s1_row_min_reg} + {1'b0, s1_row_max_reg};
    assign load_out = !out_valid_reg || points.ready;

    always_comb
    begin
        st_next   = st_reg;
        s2_load   = 1'b0;
        out_load  = 1'b0;
        pt_x      = s2_x0_reg;
        pt_row    = s2_first_row_reg;
        pt_starts = 1'b0;
        pt_last   = 1'b0;
        unique case (st_reg)
            EMIT_IDLE:
            begin
                if (s1_valid_reg)
                begin
                    s2_load = 1'b1;
                    st_next = EMIT_FIRST;
                end
            end
            EMIT_FIRST:
            begin
                pt_x      = s2_x0_reg;
                pt_row    = s2_first_row_reg;
                pt_starts = s2_starts_reg;
                if (load_out)
                begin
                    out_load = 1'b1;
                    st_next  = EMIT_MID;
                end
            end
            EMIT_MID:
            begin
                pt_x   = s2_x1_reg;
                pt_row = s2_mid_row_reg;
                if (load_out)
                begin
                    out_load = 1'b1;
                    st_next  = EMIT_LAST;
                end
            end
            EMIT_LAST:
            begin
                pt_x    = s2_x2_reg;
                pt_row  = s2_last_row_reg;
                pt_last = 1'b1;
                if (load_out)
                begin
                    out_load = 1'b1;
                    s2_load  = s1_valid_reg;
                    st_next  = s1_valid_reg ? EMIT_FIRST : EMIT_IDLE;
                end
            end
            default:
            begin
                st_next = EMIT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_first_row_reg <= s1_min_first_reg ? s1_row_min_reg : s1_row_max_reg;
            s2_last_row_reg  <= s1_min_first_reg ? s1_row_max_reg : s1_row_min_reg;
            s2_mid_row_reg   <= row_sum[ROW_W:1];
            s2_starts_reg    <= s1_starts_reg;
            s2_x0_reg        <= s1_x0_reg;
            s2_x1_reg        <= s1_x1_reg;
            s2_x2_reg        <= s1_x2_reg;
        end
        if (out_load)
        begin
            out_x_reg      <= pt_x;
            out_row_reg    <= pt_row;
            out_starts_reg <= pt_starts;
            out_last_reg   <= pt_last;
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (points.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            st_reg        <= EMIT_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign points.valid       = out_valid_reg;
    assign points.x_position  = out_x_reg;
    assign points.y_row       = out_row_reg;
    assign points.starts_path = out_starts_reg;
    assign points.last_of_run = out_last_reg;

`ifndef SYNTHESIS
    a_load_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |-> s1_valid_reg)
        else $error("sequencer loaded from an empty scaling stage");

    a_mid_between: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != EMIT_IDLE |->
            (s2_mid_row_reg >= s2_first_row_reg && s2_mid_row_reg <= s2_last_row_reg) ||
            (s2_mid_row_reg >= s2_last_row_reg && s2_mid_row_reg <= s2_first_row_reg))
        else $error("mean row outside the extreme rows");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != EMIT_IDLE && out_valid_reg && !points.ready |=> st_reg == $past(st_reg))
        else $error("point sequencer advanced while output stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/waveform_min_max_decimator_core.sv =====
// Top level of the waveform min/max decimator: config registers, front, queue, back.
//
// Usage:
//   samples : valid/ready channel of signed samples plus an end_of_view flag.
//   points  : valid/ready channel of drawing points (x_position, y_row,
//             starts_path, last_of_run); three points per completed window.
//   cfg     : write channel, index 0 = window_length, index 1 = view_height;
//             always ready, write only while the block is idle.
// Throughput: one sample per cycle while the queue has room. Each window of at
//   least four samples produces three points, and the back end emits one point
//   per cycle to a ready receiver, which then never slows the sample side.
// Path: the first point of a window passes the queue, the scaling register, the
//   point sequencer and the output register after the transaction that
//   completes the window; the other two follow when the receiver is ready.
// Stall: the output register holds a point until taken; completed windows
//   collect in a 4-deep record queue, and samples.ready drops only when it is
//   full. The sequencer goes straight on to a waiting window, else via idle.
// Reset: window_length 4, view_height 256, empty window, no path open, queue
//   and output empty.
`default_nettype none

module waveform_min_max_decimator_core #(
    parameter int MAX_WINDOW    = 4096,
    parameter int SAMPLE_BITS   = 16,
    parameter int POSITION_BITS = 24
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    wmmd_cfg_if.sink     cfg,
    wmmd_sample_if.sink  samples,
    wmmd_point_if.source points
);
    import wmmd_pkg::*;

    localparam int REC_W = 2 * SAMPLE_BITS + 3 * POSITION_BITS + 2;

    logic [WLEN_W-1:0]   window_length_reg, window_length_next;
    logic [HEIGHT_W-1:0] view_height_reg, view_height_next;

    logic                q_push;
    logic [REC_W-1:0]    q_push_data;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    logic [REC_W-1:0]    q_head;

    // Configuration writes always complete in the cycle they are offered
    assign cfg.ready = 1'b1;

    always_comb
    begin
        window_length_next = window_length_reg;
        view_height_next   = view_height_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WINDOW_LENGTH: window_length_next = cfg.data[WLEN_W-1:0];
                REG_VIEW_HEIGHT:   view_height_next   = cfg.data[HEIGHT_W-1:0];
                default:           ;   // drop writes to unused indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_LENGTH_RST;
            view_height_reg   <= VIEW_HEIGHT_RST;
        end
        else
        begin
            window_length_reg <= window_length_next;
            view_height_reg   <= view_height_next;
        end
    end

    // Front: classify samples into windows and push one record per completed window
    wmmd_front #(
        .MAX_WINDOW    (MAX_WINDOW),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples),
        .window_length (window_length_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    // Queue: decouple the sample side from the point side
    wmmd_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // Back: scale extremes to rows and emit the three points of each window
    wmmd_back #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .view_height (view_height_reg),
        .q_valid     (q_valid),
        .q_data      (q_head),
        .q_pop       (q_pop),
        .points      (points)
    );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the waveform min/max decimator core.
`default_nettype none

module testbench;
    import wmmd_pkg::*;

    localparam int SAMPLE_BITS      = 16;
    localparam int POSITION_BITS    = 24;
    localparam int MAX_WINDOW       = 4096;
    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 8;
    // Leave a wide margin for the pipeline to empty.
    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS     = 500;
    // Several times the slowest legal run.
    localparam int TIMEOUT_TIME     = 20_000_000;

    // One drawing point as it leaves the block.
    typedef struct packed {
        logic [POSITION_BITS-1:0] x_position;
        logic [ROW_W-1:0]         y_row;
        logic                     starts_path;
        logic                     last_of_run;
    } draw_point_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    // One line of the directed table: either a register write or a sample.
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   end_of_view;
        logic                   typed;
        draw_point_t [2:0]      typed_pts;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wmmd_cfg_if                                      cfg_ch ();
    wmmd_sample_if #(.SAMPLE_BITS(SAMPLE_BITS))      sample_ch ();
    wmmd_point_if  #(.POSITION_BITS(POSITION_BITS))  point_ch ();

    waveform_min_max_decimator_core #(
        .MAX_WINDOW    (MAX_WINDOW),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (sample_ch),
        .points  (point_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Decimator model: register copies and window state
    // ------------------------------------------------------------------
    logic [WLEN_W-1:0]             cur_window_length = WINDOW_LENGTH_RST;
    logic [HEIGHT_W-1:0]           cur_view_height   = VIEW_HEIGHT_RST;
    logic signed [SAMPLE_BITS-1:0] win_min           = 16'sh7fff;
    logic signed [SAMPLE_BITS-1:0] win_max           = 16'sh8000;
    logic [11:0]                   win_min_pos       = '0;
    logic [11:0]                   win_max_pos       = '0;
    logic [WLEN_W-1:0]             win_fill          = '0;
    logic [POSITION_BITS-1:0]      win_start         = '0;
    logic                          path_started      = 1'b0;
    draw_point_t [2:0]             model_pts;

    // Points still owed by the block, oldest first.
    draw_point_t pending_points[$];
    stim_row_t   directed_rows[$];

    int error_count   = 0;
    bit idling_on     = 1'b1;
    bit long_hold_req = 1'b0;

    function automatic void clear_window_model();
        win_min     = 16'sh7fff;
        win_max     = 16'sh8000;
        win_min_pos = '0;
        win_max_pos = '0;
        win_fill    = '0;
    endfunction

    // Map a sample onto a pixel row: full positive lands near row 0.
    function automatic logic [ROW_W-1:0] pixel_row(input logic signed [SAMPLE_BITS-1:0] s);
        int span;
        span = (1 << (SAMPLE_BITS - 1)) - int'(s);
        return ROW_W'((span * int'(cur_view_height)) >> SAMPLE_BITS);
    endfunction

    // Fold one sample into the window; return how many points it releases.
    function automatic int decimate_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                           input logic eov);
        logic [WLEN_W-1:0]        len;
        logic [ROW_W-1:0]         row_lo;
        logic [ROW_W-1:0]         row_hi;
        logic [ROW_W-1:0]         row_mid;
        logic [POSITION_BITS-1:0] x_end;
        logic                     min_first;
        int                       produced;
        produced = 0;
        len = cur_window_length;
        if (len < MIN_WINDOW)
            len = WLEN_W'(MIN_WINDOW);
        if (len > MAX_WINDOW)
            len = WLEN_W'(MAX_WINDOW);
        // Ties move the position forward: last occurrence wins.
        if (s <= win_min)
        begin
            win_min     = s;
            win_min_pos = win_fill[11:0];
        end
        if (s >= win_max)
        begin
            win_max     = s;
            win_max_pos = win_fill[11:0];
        end
        win_fill = win_fill + 1'b1;
        if (win_fill >= len)
        begin
            row_lo    = pixel_row(win_min);
            row_hi    = pixel_row(win_max);
            row_mid   = ROW_W'(({1'b0, row_lo} + {1'b0, row_hi}) >> 1);
            min_first = win_min_pos < win_max_pos;
            x_end     = win_start + POSITION_BITS'(len);
            model_pts[0] = '{win_start, min_first ? row_lo : row_hi, !path_started, 1'b0};
            model_pts[1] = '{win_start + POSITION_BITS'(len >> 1), row_mid, 1'b0, 1'b0};
            model_pts[2] = '{x_end, min_first ? row_hi : row_lo, 1'b0, 1'b1};
            produced     = 3;
            path_started = 1'b1;
            win_start    = x_end;
            clear_window_model();
        end
        // The end marker drops any partial window and closes the path.
        if (eov)
        begin
            clear_window_model();
            win_start    = '0;
            path_started = 1'b0;
        end
        return produced;
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    function automatic draw_point_t pt(input int x, input int y, input bit sp, input bit last);
        draw_point_t p;
        p.x_position  = POSITION_BITS'(x);
        p.y_row       = ROW_W'(y);
        p.starts_path = sp;
        p.last_of_run = last;
        return p;
    endfunction

    function automatic void add_sample(input int value, input bit eov);
        stim_row_t row;
        row             = '0;
        row.kind        = ROW_SAMPLE;
        row.sample      = SAMPLE_BITS'(value);
        row.end_of_view = eov;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_INDEX_W-1:0] index, input int value);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_WRITE;
        row.reg_index = index;
        row.reg_data  = CFG_DATA_W'(value);
        directed_rows.push_back(row);
    endfunction

    // Attach hand-computed points to the sample row just added.
    function automatic void add_points(input draw_point_t p0, input draw_point_t p1,
                                       input draw_point_t p2);
        stim_row_t row;
        row           = directed_rows.pop_back();
        row.typed     = 1'b1;
        row.typed_pts = {p2, p1, p0};
        directed_rows.push_back(row);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            // small values around zero produce plenty of ties
            2:       return SAMPLE_BITS'($urandom_range(0, 16) - 8);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one sample, hold it until the transaction completes, then predict.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic eov,
                               input logic typed, input draw_point_t [2:0] typed_pts);
        int produced;
        sample_ch.valid       <= 1'b1;
        sample_ch.sample      <= value;
        sample_ch.end_of_view <= eov;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        produced = decimate_sample(value, eov);
        if (typed)
            produced = 3;
        for (int k = 0; k < produced; k++)
            pending_points.push_back(typed ? typed_pts[k] : model_pts[k]);
    endtask

    // Drop valid for a random burst now and then.
    task automatic sender_gap();
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Hold off until every owed point is out, then let the pipeline settle.
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (index == REG_WINDOW_LENGTH)
            cur_window_length = WLEN_W'(value);
        else if (index == REG_VIEW_HEIGHT)
            cur_view_height = HEIGHT_W'(value);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        point_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                // Starve the output long enough to fill the record queue.
                long_hold_req = 1'b0;
                point_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                point_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                point_ch.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                point_ch.ready <= 1'b0;
            end
            else
                point_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Point checker
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : point_checker
        draw_point_t want;
        if (rst_n && point_ch.valid && point_ch.ready)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected point, expected none, actual x=%0d y=%0d",
                         $time, point_ch.x_position, point_ch.y_row);
                error_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                check_field("x_position", 32'(want.x_position), 32'(point_ch.x_position));
                check_field("y_row", 32'(want.y_row), 32'(point_ch.y_row));
                check_field("starts_path", 32'(want.starts_path),
                            32'(point_ch.starts_path));
                check_field("last_of_run", 32'(want.last_of_run),
                            32'(point_ch.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed table, then random phases
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t row;
        int        n_items;
        int        random_items;
        int        phase;
        logic      eov;

        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= '0;
        cfg_ch.data           <= '0;
        sample_ch.valid       <= 1'b0;
        sample_ch.sample      <= '0;
        sample_ch.end_of_view <= 1'b0;

        // Reset defaults (length 4, height 256): max comes first.
        add_sample(32767, 0);
        add_sample(-32768, 0);
        add_sample(0, 0);
        add_sample(0, 0);
        add_points(pt(0, 0, 1, 0), pt(2, 128, 0, 0), pt(4, 256, 0, 1));
        // Min comes first; path already open.
        add_sample(-32768, 0);
        add_sample(32767, 0);
        add_sample(5, 0);
        add_sample(5, 0);
        add_points(pt(4, 256, 0, 0), pt(6, 128, 0, 0), pt(8, 0, 0, 1));
        // Flat window: ties put both extremes on the last sample.
        add_sample(0, 0);
        add_sample(0, 0);
        add_sample(0, 0);
        add_sample(0, 0);
        add_points(pt(8, 128, 0, 0), pt(10, 128, 0, 0), pt(12, 128, 0, 1));
        // End marker on a partial window: dropped, position back to zero.
        add_sample(100, 1);
        // End marker on the completing sample: window still emitted, new path.
        add_sample(1, 0);
        add_sample(2, 0);
        add_sample(3, 0);
        add_sample(4, 1);
        add_points(pt(0, 127, 1, 0), pt(2, 127, 0, 0), pt(4, 127, 0, 1));
        // Length below the minimum and zero height.
        add_write(REG_WINDOW_LENGTH, 0);
        add_write(REG_VIEW_HEIGHT, 0);
        add_sample(12345, 0);
        add_sample(-1, 0);
        add_sample(-32768, 0);
        add_sample(32767, 0);
        // Tallest view, then shrink the length mid-window past the count.
        add_write(REG_WINDOW_LENGTH, 7);
        add_write(REG_VIEW_HEIGHT, 4095);
        add_sample(-32768, 0);
        add_sample(32767, 0);
        add_sample(-7, 0);
        add_sample(0, 0);
        add_sample(1, 0);
        add_write(REG_WINDOW_LENGTH, 2);
        add_sample(-32768, 1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
                write_register(row.reg_index, 32'(row.reg_data));
            else
            begin
                send_sample(row.sample, row.end_of_view, row.typed, row.typed_pts);
                sender_gap();
            end
        end

        // Random phases: reconfigure while idle, then stream a burst of samples.
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            // Run the tail of the test without any idling.
            idling_on = random_items < (RANDOM_ITEMS * 4) / 5;
            if (phase == 2)
            begin
                // Shortest windows against a stalled receiver fill the queue.
                write_register(REG_WINDOW_LENGTH, MIN_WINDOW);
                long_hold_req = 1'b1;
                n_items = 48;
            end
            else if (phase == 5 || phase == 9)
            begin
                // Long windows stay open; a later shorter length closes them at once.
                write_register(REG_WINDOW_LENGTH,
                               phase == 5 ? MAX_WINDOW : $urandom_range(MAX_WINDOW + 1, 8191));
                n_items = $urandom_range(8, 40);
            end
            else
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    case ($urandom_range(0, 7))
                        0:       write_register(REG_WINDOW_LENGTH, $urandom_range(0, 3));
                        1:       write_register(REG_WINDOW_LENGTH, $urandom_range(13, 64));
                        default: write_register(REG_WINDOW_LENGTH, $urandom_range(4, 12));
                    endcase
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    case ($urandom_range(0, 5))
                        0:       write_register(REG_VIEW_HEIGHT, 0);
                        1:       write_register(REG_VIEW_HEIGHT, 1);
                        2:       write_register(REG_VIEW_HEIGHT, 4095);
                        default: write_register(REG_VIEW_HEIGHT, $urandom_range(1, 4095));
                    endcase
                end
                n_items = $urandom_range(8, 40);
            end

            for (int i = 0; i < n_items; i++)
            begin
                eov = $urandom_range(0, 19) == 0;
                send_sample(random_sample(), eov, 1'b0, '0);
                sender_gap();
                random_items++;
            end
            phase++;
        end

        wait_drained();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin : watchdog
        #(TIMEOUT_TIME);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
